// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the gamma core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OGAM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OGAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ogam_pkg.sv =====
// Package of the gamma core: sizes, register indexes, payload types and helpers.
package ogam_pkg;

    // table geometry and count width
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int IDX_BITS    = ADDR_BITS + 1;
    localparam int ROW_BITS    = $clog2(MAX_ROWS + 1);
    localparam int COL_BITS    = $clog2(MAX_COLS + 1);

    // suffix sums, products, accumulators
    localparam int SUM_BITS    = COUNT_BITS + ADDR_BITS;
    localparam int PROD_BITS   = COUNT_BITS + SUM_BITS;
    localparam int ACC_BITS    = 48;
    localparam int DEN_BITS    = ACC_BITS + 1;
    localparam int REM_BITS    = DEN_BITS + 1;
    localparam int WIDE_BITS   = ((PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS) + 1;
    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    // gamma in Q1.15
    localparam int GAMMA_BITS   = 16;
    localparam int FRAC_BITS    = GAMMA_BITS - 1;
    localparam int DIV_CNT_BITS = $clog2(GAMMA_BITS + 1);
    localparam logic [GAMMA_BITS-1:0] GAMMA_POS_MAX = {1'b0, {FRAC_BITS{1'b1}}};

    // configuration registers
    localparam int DIM_BITS       = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [DIM_BITS-1:0]       DIM_RESET    = DIM_BITS'(16);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_ROWS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_COLS = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [COUNT_BITS-1:0] cell_count;
        logic                  last_cell;
    } ogam_in_t;

    typedef struct packed {
        logic signed [GAMMA_BITS-1:0] gamma_value;
        logic [ACC_BITS-1:0]          concordant_sum;
        logic [ACC_BITS-1:0]          discordant_sum;
        logic                         undefined;
    } ogam_out_t;

    // divider request and response
    typedef struct packed {
        logic                start;
        logic [ACC_BITS-1:0] mag;
        logic [DEN_BITS-1:0] den;
    } ogam_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [GAMMA_BITS-1:0] quot;
    } ogam_div_rsp_t;

    // saturate the row count into 2..MAX_ROWS
    function automatic logic [ROW_BITS-1:0] clamp_rows(input logic [DIM_BITS-1:0] v);
        int unsigned x;
        x = v;
        if (x < 2) x = 2;
        if (x > MAX_ROWS) x = MAX_ROWS;
        return ROW_BITS'(x);
    endfunction

    // saturate the column count into 2..MAX_COLS
    function automatic logic [COL_BITS-1:0] clamp_cols(input logic [DIM_BITS-1:0] v);
        int unsigned x;
        x = v;
        if (x < 2) x = 2;
        if (x > MAX_COLS) x = MAX_COLS;
        return COL_BITS'(x);
    endfunction

    // accumulate a product, saturating at the 48-bit ceiling
    function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                    input logic [PROD_BITS-1:0] b);
        logic [WIDE_BITS-1:0] s;
        s = WIDE_BITS'(a) + WIDE_BITS'(b);
        if (s >= WIDE_BITS'(ACC_MAX)) return ACC_MAX;
        return ACC_BITS'(s);
    endfunction

endpackage

// ===== hdl/ordinal_gamma_association_core.sv =====
// Goodman-Kruskal gamma core: stores a table of counts, then evaluates C, D and gamma.
// Loading: one cell request per cycle; s_ready is low from the last cell until the result is out.
// After the last cell: the suffix-sum pass and the pair pass (one store entry a cycle), then the 17-step divider.
// Reset: aresetn, synchronous, active low; rows and columns go to 16, sums and load index to 0.
`include "assert_macros.svh"

module ordinal_gamma_association_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ogam_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ogam_pkg::DIM_BITS-1:0]       cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ogam_pkg::ogam_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ogam_pkg::ogam_out_t                 m_data
);
    import ogam_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_P1, S_P1_DRAIN, S_P2, S_P2_DRAIN, S_DIV, S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [DIM_BITS-1:0]  rows_cfg_reg, rows_cfg_next;
    logic [DIM_BITS-1:0]  cols_cfg_reg, cols_cfg_next;
    logic [IDX_BITS-1:0]  load_idx_reg, load_idx_next;
    logic [ROW_BITS-1:0]  rows_reg, rows_next;
    logic [COL_BITS-1:0]  cols_reg, cols_next;
    logic [ROW_BITS-1:0]  r_reg, r_next;
    logic [COL_BITS-1:0]  c_reg, c_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] p_reg, p_next;

    // read-return stage
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_rlast_reg, s1_rlast_next;
    logic                 s1_clast_reg, s1_clast_next;
    logic                 s1_jzero_reg, s1_jzero_next;
    logic                 s1_jend_reg, s1_jend_next;
    logic [ADDR_BITS-1:0] s1_addr_reg, s1_addr_next;

    // suffix-sum pass
    logic [SUM_BITS-1:0]  prev_s_reg, prev_s_next;
    logic [SUM_BITS-1:0]  prev_right_reg, prev_right_next;

    // pair pass
    logic [SUM_BITS-1:0]   below_all_reg, below_all_next;
    logic [COUNT_BITS-1:0] prev_n_reg, prev_n_next;
    logic [SUM_BITS-1:0]   prev_sfx_reg, prev_sfx_next;
    logic [PROD_BITS-1:0]  prodc_reg, prodc_next;
    logic [PROD_BITS-1:0]  prodd_reg, prodd_next;
    logic                  prod_valid_reg, prod_valid_next;
    logic [ACC_BITS-1:0]   concord_reg, concord_next;
    logic [ACC_BITS-1:0]   discord_reg, discord_next;

    logic                  div_start_reg, div_start_next;
    logic                  m_valid_reg, m_valid_next;
    ogam_out_t             m_data_reg, m_data_next;

    // memory ports
    logic                  cell_we, cell_re;
    logic [ADDR_BITS-1:0]  cell_waddr, cell_raddr;
    logic [COUNT_BITS-1:0] cell_rdata;
    logic                  sfx_we, sfx_re;
    logic [ADDR_BITS-1:0]  sfx_waddr, sfx_raddr;
    logic [SUM_BITS-1:0]   sfx_wdata, sfx_rdata;

    // combinational helpers
    logic                  in_fire, is_p1, is_p2, issue;
    logic [ROW_BITS-1:0]   rows_eff;
    logic [COL_BITS-1:0]   cols_eff;
    logic [SUM_BITS-1:0]   right, below, diag, sfx_new, sfx2, left;
    logic [DEN_BITS-1:0]   den_full;
    logic                  neg;
    ogam_div_req_t         div_req;
    ogam_div_rsp_t         div_rsp;
    ogam_out_t             res;

    ogam_ram #(.WIDTH(COUNT_BITS), .DEPTH(STORE_DEPTH)) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (s_data.cell_count),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    ogam_ram #(.WIDTH(SUM_BITS), .DEPTH(STORE_DEPTH)) u_sfx_ram (
        .aclk  (aclk),
        .we    (sfx_we),
        .waddr (sfx_waddr),
        .wdata (sfx_wdata),
        .re    (sfx_re),
        .raddr (sfx_raddr),
        .rdata (sfx_rdata)
    );

    ogam_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // handshake and pass decode
    assign s_ready  = (state_reg == S_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign is_p1    = (state_reg == S_P1) || (state_reg == S_P1_DRAIN);
    assign is_p2    = (state_reg == S_P2) || (state_reg == S_P2_DRAIN);
    assign issue    = (state_reg == S_P1) || (state_reg == S_P2);
    assign rows_eff = clamp_rows(rows_cfg_reg);
    assign cols_eff = clamp_cols(cols_cfg_reg);

    // cell store: written while loading, read by both passes
    assign cell_we    = in_fire && !load_idx_reg[ADDR_BITS];
    assign cell_waddr = load_idx_reg[ADDR_BITS-1:0];
    assign cell_re    = issue;
    assign cell_raddr = (state_reg == S_P1) ? addr_reg : p_reg;

    // suffix store: pass one reads the column to the right, pass two the row below
    assign sfx_re    = issue;
    assign sfx_raddr = (state_reg == S_P1) ? addr_reg + ADDR_BITS'(rows_reg)
                                           : p_reg + ADDR_BITS'(1);
    assign sfx_we    = s1_valid_reg && is_p1;
    assign sfx_waddr = s1_addr_reg;
    assign sfx_wdata = sfx_new;

    // suffix sum at (r, c): cell + below + right - diagonal
    assign right   = s1_clast_reg ? '0 : sfx_rdata;
    assign below   = s1_rlast_reg ? '0 : prev_s_reg;
    assign diag    = (s1_rlast_reg || s1_clast_reg) ? '0 : prev_right_reg;
    assign sfx_new = SUM_BITS'(cell_rdata) + below + right - diag;

    // pair pass operands
    assign sfx2 = s1_jend_reg ? '0 : sfx_rdata;
    assign left = below_all_reg - prev_sfx_reg;

    // divider request from the final sums
    assign den_full      = DEN_BITS'(concord_reg) + DEN_BITS'(discord_reg);
    assign neg           = discord_reg > concord_reg;
    assign div_req.start = div_start_reg;
    assign div_req.den   = den_full;
    assign div_req.mag   = neg ? discord_reg - concord_reg : concord_reg - discord_reg;

    // result word
    always_comb begin
        res.concordant_sum = concord_reg;
        res.discordant_sum = discord_reg;
        res.undefined      = (den_full == '0);
        if (den_full == '0) begin
            res.gamma_value = '0;
        end else if (neg) begin
            res.gamma_value = $signed(GAMMA_BITS'(0) - div_rsp.quot);
        end else if (div_rsp.quot > GAMMA_POS_MAX) begin
            res.gamma_value = $signed(GAMMA_POS_MAX);
        end else begin
            res.gamma_value = $signed(div_rsp.quot);
        end
    end

    // sequencer and datapath next state
    always_comb begin
        state_next      = state_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        load_idx_next   = load_idx_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        addr_next       = addr_reg;
        p_next          = p_reg;
        s1_valid_next   = 1'b0;
        s1_rlast_next   = s1_rlast_reg;
        s1_clast_next   = s1_clast_reg;
        s1_jzero_next   = s1_jzero_reg;
        s1_jend_next    = s1_jend_reg;
        s1_addr_next    = s1_addr_reg;
        prev_s_next     = prev_s_reg;
        prev_right_next = prev_right_reg;
        below_all_next  = below_all_reg;
        prev_n_next     = prev_n_reg;
        prev_sfx_next   = prev_sfx_reg;
        prodc_next      = prodc_reg;
        prodd_next      = prodd_reg;
        prod_valid_next = 1'b0;
        concord_next    = concord_reg;
        discord_next    = discord_reg;
        div_start_next  = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_NUM_ROWS: rows_cfg_next = cfg_data;
                CFG_NUM_COLS: cols_cfg_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    if (!load_idx_reg[ADDR_BITS]) begin
                        load_idx_next = load_idx_reg + IDX_BITS'(1);
                    end
                    if (s_data.last_cell) begin
                        rows_next  = rows_eff;
                        cols_next  = cols_eff;
                        addr_next  = ADDR_BITS'(rows_eff * cols_eff - 1);
                        r_next     = rows_eff - ROW_BITS'(1);
                        c_next     = cols_eff - COL_BITS'(1);
                        state_next = S_P1;
                    end
                end
            end
            S_P1: begin
                // walk the table backwards, bottom-right corner first
                s1_valid_next = 1'b1;
                s1_rlast_next = (r_reg == rows_reg - ROW_BITS'(1));
                s1_clast_next = (c_reg == cols_reg - COL_BITS'(1));
                s1_addr_next  = addr_reg;
                if (addr_reg == '0) begin
                    state_next = S_P1_DRAIN;
                end else begin
                    addr_next = addr_reg - ADDR_BITS'(1);
                    if (r_reg == '0) begin
                        r_next = rows_reg - ROW_BITS'(1);
                        c_next = c_reg - COL_BITS'(1);
                    end else begin
                        r_next = r_reg - ROW_BITS'(1);
                    end
                end
            end
            S_P1_DRAIN: begin
                r_next       = '0;
                c_next       = '0;
                p_next       = '0;
                concord_next = '0;
                discord_next = '0;
                state_next   = S_P2;
            end
            S_P2: begin
                // one extra step per row closes the last column's products
                s1_valid_next = 1'b1;
                s1_jzero_next = (c_reg == '0);
                s1_jend_next  = (c_reg == cols_reg);
                if (c_reg == cols_reg) begin
                    if (r_reg == rows_reg - ROW_BITS'(2)) begin
                        state_next = S_P2_DRAIN;
                    end else begin
                        r_next = r_reg + ROW_BITS'(1);
                        c_next = '0;
                        p_next = ADDR_BITS'(r_reg) + ADDR_BITS'(1);
                    end
                end else begin
                    c_next = c_reg + COL_BITS'(1);
                    p_next = p_reg + ADDR_BITS'(rows_reg);
                end
            end
            S_P2_DRAIN: begin
                if (!s1_valid_reg && !prod_valid_reg) begin
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res;
                    load_idx_next = '0;
                    concord_next  = '0;
                    discord_next  = '0;
                    state_next    = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        // suffix pass: keep the value just written and the right-hand read
        if (s1_valid_reg && is_p1) begin
            prev_s_next     = sfx_new;
            prev_right_next = right;
        end

        // pair pass: products for the cell left behind
        if (s1_valid_reg && is_p2) begin
            if (s1_jzero_reg) begin
                below_all_next = sfx2;
            end else begin
                prodc_next      = prev_n_reg * sfx2;
                prodd_next      = prev_n_reg * left;
                prod_valid_next = 1'b1;
            end
            prev_n_next   = cell_rdata;
            prev_sfx_next = sfx2;
        end

        // accumulate
        if (prod_valid_reg) begin
            concord_next = sat_add(concord_reg, prodc_reg);
            discord_next = sat_add(discord_reg, prodd_reg);
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            rows_cfg_reg   <= DIM_RESET;
            cols_cfg_reg   <= DIM_RESET;
            load_idx_reg   <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            addr_reg       <= '0;
            p_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            concord_reg    <= '0;
            discord_reg    <= '0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rows_cfg_reg   <= rows_cfg_next;
            cols_cfg_reg   <= cols_cfg_next;
            load_idx_reg   <= load_idx_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            addr_reg       <= addr_next;
            p_reg          <= p_next;
            s1_valid_reg   <= s1_valid_next;
            prod_valid_reg <= prod_valid_next;
            concord_reg    <= concord_next;
            discord_reg    <= discord_next;
            div_start_reg  <= div_start_next;
            m_valid_reg    <= m_valid_next;
        end
        rows_reg       <= rows_next;
        cols_reg       <= cols_next;
        s1_rlast_reg   <= s1_rlast_next;
        s1_clast_reg   <= s1_clast_next;
        s1_jzero_reg   <= s1_jzero_next;
        s1_jend_reg    <= s1_jend_next;
        s1_addr_reg    <= s1_addr_next;
        prev_s_reg     <= prev_s_next;
        prev_right_reg <= prev_right_next;
        below_all_reg  <= below_all_next;
        prev_n_reg     <= prev_n_next;
        prev_sfx_reg   <= prev_sfx_next;
        prodc_reg      <= prodc_next;
        prodd_reg      <= prodd_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `OGAM_ASSERT_IMPL(a_sfx_no_collide, aclk, aresetn, sfx_we && sfx_re, sfx_waddr != sfx_raddr, "suffix store read and write collide")
    `OGAM_ASSERT_IMPL(a_load_idle, aclk, aresetn, s_ready, !s1_valid_reg && !prod_valid_reg, "pipeline busy while loading cells")
    `OGAM_ASSERT_NEXT(a_div_after_drain, aclk, aresetn, div_start_reg, !prod_valid_reg && state_reg == S_DIV, "divider started before the sums settled")

endmodule

// ===== hdl/ogam_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ogam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ogam_div.sv =====
// Restoring divider giving the rounded Q1.15 quotient of |C-D| over C+D.
`include "assert_macros.svh"

module ogam_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ogam_pkg::ogam_div_req_t div_req,
    output ogam_pkg::ogam_div_rsp_t div_rsp
);
    import ogam_pkg::*;

    typedef enum logic {D_IDLE, D_RUN} state_t;

    state_t                  state_reg, state_next;
    logic [REM_BITS-1:0]     rem_reg, rem_next;
    logic [DEN_BITS-1:0]     den_reg, den_next;
    logic [GAMMA_BITS-1:0]   q_reg, q_next;
    logic [GAMMA_BITS-1:0]   quot_reg, quot_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic                    ge;
    logic [REM_BITS-1:0]     diff;

    // one quotient bit per cycle, then a final compare for round-half-up
    always_comb begin
        ge         = rem_reg >= {1'b0, den_reg};
        diff       = rem_reg - {1'b0, den_reg};
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (div_req.start) begin
                    rem_next   = REM_BITS'(div_req.mag);
                    den_next   = div_req.den;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (cnt_reg == DIV_CNT_BITS'(GAMMA_BITS)) begin
                    // remainder doubled already: ge means rem >= den - rem
                    quot_next  = q_reg + GAMMA_BITS'(ge);
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else begin
                    q_next   = {q_reg[GAMMA_BITS-2:0], ge};
                    rem_next = ge ? {diff[DEN_BITS-1:0], 1'b0}
                                  : {rem_reg[DEN_BITS-1:0], 1'b0};
                    cnt_next = cnt_reg + DIV_CNT_BITS'(1);
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quot_reg;

    `OGAM_ASSERT_IMPL(a_start_idle, aclk, aresetn, div_req.start, state_reg == D_IDLE, "divider restarted while busy")
    `OGAM_ASSERT_IMPL(a_quot_range, aclk, aresetn, div_rsp.done, div_rsp.quot <= (GAMMA_BITS'(1) << FRAC_BITS), "quotient above one")

endmodule
